>>> hw/rtl/average_true_range_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the average true range block
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef AVERAGE_TRUE_RANGE_MACROS_SVH
`define AVERAGE_TRUE_RANGE_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset
`define ATR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check a property on every rising edge, reset included
`define ATR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATR_ASSERT(lbl, clk, rst, prop, msg)
`define ATR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/atr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_pkg
// Shared types and fixed constants of the average true range block.
// ----------------------------------------------------------------------------
package atr_pkg;

  localparam int DATA_W   = 32;
  localparam int PERIOD_W = 9;
  // partial remainder of the divider: one bit above the divisor
  localparam int REM_W    = PERIOD_W + 1;
  // quotient bit counter, counts DATA_W down to zero
  localparam int QCNT_W   = $clog2(DATA_W + 1);

  typedef logic [DATA_W-1:0]   price_t;
  typedef logic [PERIOD_W-1:0] period_t;

  localparam period_t PERIOD_RESET = period_t'(14);

endpackage

>>> hw/rtl/atr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_in_if / atr_out_if
// Valid/ready channels for price bars and averaged ranges.
// ----------------------------------------------------------------------------
interface atr_in_if;
  logic            valid;
  logic            ready;
  atr_pkg::price_t high_price;
  atr_pkg::price_t low_price;
  atr_pkg::price_t prior_close;

  modport source (output valid, output high_price, output low_price,
                  output prior_close, input ready);
  modport sink   (input valid, input high_price, input low_price,
                  input prior_close, output ready);
endinterface

interface atr_out_if;
  logic            valid;
  logic            ready;
  atr_pkg::price_t average_range;

  modport source (output valid, output average_range, input ready);
  modport sink   (input valid, input average_range, output ready);
endinterface

>>> hw/rtl/average_true_range.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// average_true_range
// Simple moving average of the true range over a configurable window.
// ----------------------------------------------------------------------------
// Usage:
//   in_bar  (sink)  : one request per price bar (high, low, previous close).
//   out_avg (source): one request per bar once the window holds period bars,
//                     carrying the window sum divided by period, truncated.
//   cfg_wr_en/cfg_wr_data: write the period; any write restarts the window.
//   Write the period only while the block is idle.
// Sequence:
//   A bar is taken while idle, its range leaving the window is read from
//   the ring memory in the next cycle, and the sum is updated then. A bar
//   that completes no window then returns to idle. A bar with a result runs
//   the bit-serial divider, then loads the result register once out_avg is free;
//   no new bar is taken until the block is idle again.
// Reset: period returns to 14, the window is empty; the ring memory is not
//   cleared, since only entries written since the restart are read.
// Stall: the result register holds its request while out_avg is stalled;
//   the next bar is taken meanwhile and waits before loading its result.
// ----------------------------------------------------------------------------
`include "average_true_range_macros.svh"

module average_true_range #(
  parameter int MAX_WINDOW = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  atr_pkg::period_t cfg_wr_data,
  atr_in_if.sink           in_bar,
  atr_out_if.source        out_avg
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SUM_W = atr_pkg::DATA_W + IDX_W;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_UPDATE = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_LOAD   = 2'd3;

  logic [1:0]             state;
  atr_pkg::period_t       period;
  atr_pkg::period_t       eff_p;
  logic [SUM_W-1:0]       window_sum;
  logic [SUM_W-1:0]       sum_next;
  logic [IDX_W-1:0]       write_slot;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       slot_hold;
  logic [IDX_W:0]         slot_inc;
  atr_pkg::period_t       filled_count;
  atr_pkg::period_t       filled_next;
  atr_pkg::price_t        tr;
  atr_pkg::price_t        tr_hold;
  atr_pkg::price_t        old_range;
  logic                   accept;
  logic                   was_full;
  logic                   div_start;
  logic                   div_done;
  atr_pkg::price_t        quotient;
  logic                   out_free;

  // clamp the period to 1..MAX_WINDOW
  always_comb begin
    eff_p = period;
    if (period == '0) begin
      eff_p = atr_pkg::period_t'(1);
    end else if (32'(period) > 32'(MAX_WINDOW)) begin
      eff_p = atr_pkg::period_t'(MAX_WINDOW);
    end
  end

  atr_tr u_tr (
    .high_price  (in_bar.high_price),
    .low_price   (in_bar.low_price),
    .prior_close (in_bar.prior_close),
    .true_range  (tr)
  );

  assign in_bar.ready = (state == S_IDLE);
  assign accept       = in_bar.valid && in_bar.ready;
  assign slot         = (32'(write_slot) < 32'(eff_p)) ? write_slot : '0;

  atr_ring #(
    .DEPTH (MAX_WINDOW),
    .IDX_W (IDX_W)
  ) u_ring (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (old_range),
    .wr_en   (state == S_UPDATE),
    .wr_addr (slot_hold),
    .wr_data (tr_hold)
  );

  // running sum, fill count and next slot
  assign was_full    = (filled_count >= eff_p);
  assign filled_next = was_full ? eff_p : filled_count + 1'b1;
  assign sum_next    = window_sum - (was_full ? SUM_W'(old_range) : '0)
                       + SUM_W'(tr_hold);
  assign slot_inc    = {1'b0, slot_hold} + 1'b1;
  assign div_start   = (state == S_UPDATE) && (filled_next >= eff_p);

  atr_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (eff_p),
    .done     (div_done),
    .quotient (quotient)
  );

  assign out_free = !out_avg.valid || out_avg.ready;

  // hold the accepted bar's range and slot
  always_ff @(posedge clk) begin
    if (accept) begin
      tr_hold   <= tr;
      slot_hold <= slot;
    end
  end

  // sequencer and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      period       <= atr_pkg::PERIOD_RESET;
      window_sum   <= '0;
      write_slot   <= '0;
      filled_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          window_sum   <= sum_next;
          filled_count <= filled_next;
          write_slot   <= (32'(slot_inc) >= 32'(eff_p)) ? '0 : slot_inc[IDX_W-1:0];
          state        <= div_start ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // restart the window on a period write
      if (cfg_wr_en) begin
        period       <= cfg_wr_data;
        window_sum   <= '0;
        write_slot   <= '0;
        filled_count <= '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_avg.valid <= 1'b0;
    end else if (state == S_LOAD && out_free) begin
      out_avg.valid <= 1'b1;
    end else if (out_avg.ready) begin
      out_avg.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && out_free) begin
      out_avg.average_range <= quotient;
    end
  end

  // checks
  `ATR_ASSERT(a_accept_update, clk, rst, accept |=> (state == S_UPDATE), "bar not updated")
  `ATR_ASSERT(a_fill_bound, clk, rst, (filled_count <= eff_p), "fill count above period")
  `ATR_ASSERT(a_slot_bound, clk, rst, (32'(write_slot) < 32'(eff_p)), "write slot outside window")
  `ATR_ASSERT(a_done_in_div, clk, rst, div_done |-> (state == S_DIV), "divider done outside divide")

endmodule

>>> hw/rtl/atr_tr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_tr
// True range of one bar: max of high-low and both gaps from previous close.
// ----------------------------------------------------------------------------
module atr_tr (
  input  atr_pkg::price_t high_price,
  input  atr_pkg::price_t low_price,
  input  atr_pkg::price_t prior_close,
  output atr_pkg::price_t true_range
);

  atr_pkg::price_t span;
  atr_pkg::price_t gap_hi;
  atr_pkg::price_t gap_lo;
  atr_pkg::price_t best;

  // drop the bar span when low sits above high
  assign span   = (high_price >= low_price) ? high_price - low_price : '0;
  assign gap_hi = (prior_close >= high_price) ? prior_close - high_price
                                              : high_price - prior_close;
  assign gap_lo = (prior_close >= low_price) ? prior_close - low_price
                                             : low_price - prior_close;

  // take the largest of the three
  assign best       = (gap_hi > span) ? gap_hi : span;
  assign true_range = (gap_lo > best) ? gap_lo : best;

endmodule

>>> hw/rtl/atr_ring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_ring
// Ring of recent true ranges: one write port, one registered read port.
// ----------------------------------------------------------------------------
module atr_ring #(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output atr_pkg::price_t      rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  atr_pkg::price_t      wr_data
);

  atr_pkg::price_t mem [DEPTH];

  // write the new range
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read the range leaving the window
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/atr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atr_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit DATA_W bits, so the upper dividend bits seed the partial remainder.
// ----------------------------------------------------------------------------
module atr_div #(
  parameter int SUM_W = 40
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [SUM_W-1:0]      dividend,
  input  atr_pkg::period_t      divisor,
  output logic                  done,
  output atr_pkg::price_t       quotient
);

  logic [atr_pkg::REM_W-1:0]  rem;
  logic [atr_pkg::REM_W-1:0]  trial;
  logic [atr_pkg::REM_W-1:0]  dvs_ext;
  atr_pkg::period_t           dvs;
  logic [atr_pkg::QCNT_W-1:0] cnt;
  logic                       fits;

  // shift in the next dividend bit and test against the divisor
  assign trial   = {rem[atr_pkg::REM_W-2:0], quotient[atr_pkg::DATA_W-1]};
  assign dvs_ext = {1'b0, dvs};
  assign fits    = (trial >= dvs_ext);

  // advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= atr_pkg::QCNT_W'(atr_pkg::DATA_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == atr_pkg::QCNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= atr_pkg::REM_W'(dividend >> atr_pkg::DATA_W);
      quotient <= dividend[atr_pkg::DATA_W-1:0];
      dvs      <= divisor;
    end else if (cnt != '0) begin
      rem      <= fits ? trial - dvs_ext : trial;
      quotient <= {quotient[atr_pkg::DATA_W-2:0], fits};
    end
  end

endmodule

>>> tb/average_true_range_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// average_true_range_tb
// Self-checking bench for the moving average of the true range. Bars go in
// through the bar channel with random gaps, and averages come out with random
// stalls and one long receiver hold-off. A scoreboard class keeps its own
// window of true ranges and compares every average in order. The period is
// rewritten between phases while the block is idle, extremes included.
// ----------------------------------------------------------------------------
module average_true_range_tb;

  localparam int WINDOW_LIMIT = 256;
  // settle time after the last average: one divide plus margin
  localparam int DRAIN_CYCLES = 64;
  localparam int LONG_HOLD_CYCLES = 400;

  typedef struct packed {
    atr_pkg::price_t high;
    atr_pkg::price_t low;
    atr_pkg::price_t close;
  } bar_t;

  // --------------------------------------------------------------------------
  // Scoreboard: windowed true range sum and queue of expected averages
  // --------------------------------------------------------------------------
  class atr_scoreboard;
    atr_pkg::price_t  range_hist [WINDOW_LIMIT];
    logic [39:0]      range_sum;
    int unsigned      next_slot;
    int unsigned      bars_held;
    atr_pkg::period_t period_reg;
    atr_pkg::price_t  expected_averages [$];
    int               errors;

    function new();
      period_reg = atr_pkg::PERIOD_RESET;
      errors = 0;
      restart();
    endfunction

    function void restart();
      range_sum = '0;
      next_slot = 0;
      bars_held = 0;
    endfunction

    // Any period write restarts the window
    function void set_period(atr_pkg::period_t p);
      period_reg = p;
      restart();
    endfunction

    function int unsigned window_len();
      if (period_reg == 0) return 1;
      if (period_reg > WINDOW_LIMIT) return WINDOW_LIMIT;
      return period_reg;
    endfunction

    function int pending();
      return expected_averages.size();
    endfunction

    // Largest of high minus low (when not negative) and the close gaps
    function atr_pkg::price_t true_range(atr_pkg::price_t h, atr_pkg::price_t l,
                                        atr_pkg::price_t c);
      atr_pkg::price_t tr;
      atr_pkg::price_t gap;
      tr = (h >= l) ? h - l : '0;
      gap = (c >= h) ? c - h : h - c;
      if (gap > tr) tr = gap;
      gap = (c >= l) ? c - l : l - c;
      if (gap > tr) tr = gap;
      return tr;
    endfunction

    // Note an accepted bar and queue the average it completes, if any
    function void note_bar(atr_pkg::price_t h, atr_pkg::price_t l, atr_pkg::price_t c);
      int unsigned p;
      int unsigned s;
      atr_pkg::price_t tr;
      p = window_len();
      s = (next_slot < p) ? next_slot : 0;
      tr = true_range(h, l, c);
      if (bars_held >= p) begin
        range_sum = range_sum - range_hist[s];
        bars_held = p;
      end else begin
        bars_held++;
      end
      range_hist[s] = tr;
      range_sum = range_sum + tr;
      s++;
      next_slot = (s >= p) ? 0 : s;
      if (bars_held >= p) expected_averages.push_back(atr_pkg::price_t'(range_sum / p));
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    // Compare one accepted average with the oldest expectation
    task check_average(atr_pkg::price_t got);
      atr_pkg::price_t want;
      if (expected_averages.size() == 0) begin
        report($sformatf("unexpected average %h", got));
      end else begin
        want = expected_averages.pop_front();
        if (got !== want) report($sformatf("average_range %h, expected %h", got, want));
      end
    endtask

    task check_leftovers();
      if (expected_averages.size() != 0)
        report($sformatf("%0d averages never arrived", expected_averages.size()));
    endtask
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  atr_pkg::period_t cfg_wr_data;

  atr_in_if  bar_if ();
  atr_out_if avg_if ();

  atr_scoreboard sb = new();

  bit idle_enabled = 1'b1;
  int long_holds_asked = 0;
  int long_holds_done = 0;
  int hold_left = 0;
  int stall_left = 0;

  average_true_range uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_bar      (bar_if),
    .out_avg     (avg_if)
  );

  // Clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Give up after a generous fixed time
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: check accepted averages, stall in short bursts or a long hold
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      avg_if.ready <= 1'b0;
    end else begin
      if (avg_if.valid && avg_if.ready) sb.check_average(avg_if.average_range);
      if (hold_left == 0 && long_holds_done != long_holds_asked) begin
        hold_left = LONG_HOLD_CYCLES;
        long_holds_done++;
      end
      if (hold_left > 0) begin
        avg_if.ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        avg_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
        avg_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 3) - 1;
      end else begin
        avg_if.ready <= 1'b1;
      end
    end
  end

  // Offer one bar, with an occasional gap first, and wait for the handshake
  task automatic send_bar(input atr_pkg::price_t h, input atr_pkg::price_t l,
                          input atr_pkg::price_t c);
    if (idle_enabled && $urandom_range(0, 4) == 0) begin
      bar_if.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    bar_if.valid       <= 1'b1;
    bar_if.high_price  <= h;
    bar_if.low_price   <= l;
    bar_if.prior_close <= c;
    @(posedge clk);
    while (!bar_if.ready) @(posedge clk);
    sb.note_bar(h, l, c);
  endtask

  // Random bar: mostly well formed, some noise, some inverted, some maximal
  function automatic bar_t random_bar(input bit heavy);
    bar_t b;
    atr_pkg::price_t spread;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (heavy && pick < 9) pick = 9;
    if (pick <= 5) begin
      spread = $urandom_range(0, 32'h000F_FFFF);
      b.low = $urandom;
      b.high = b.low + spread;
      if (b.high < b.low) b.high = '1;
      b.close = b.low + $urandom_range(0, spread) + $urandom_range(0, 32'h3_FFFF) - 32'h1_FFFF;
    end else if (pick <= 7) begin
      b.high = $urandom;
      b.low = $urandom;
      b.close = $urandom;
    end else if (pick == 8) begin
      b.high = $urandom;
      b.low = b.high + $urandom_range(1, 32'h000F_FFFF);
      b.close = $urandom_range(0, 1) ? b.high - $urandom_range(0, 32'hFFFF)
                                     : b.low + $urandom_range(0, 32'hFFFF);
    end else begin
      case ($urandom_range(0, 2))
        0: b = '{high: '1, low: '0, close: atr_pkg::price_t'($urandom)};
        1: b = '{high: '0, low: '1, close: $urandom_range(0, 1) ? '1 : '0};
        default: b = '{high: '1, low: '1, close: '0};
      endcase
    end
    return b;
  endfunction

  task automatic send_random(input int count, input bit heavy);
    bar_t b;
    repeat (count) begin
      b = random_bar(heavy);
      send_bar(b.high, b.low, b.close);
    end
  endtask

  // Stop offering, wait for all averages, then let the divider settle
  task automatic drain_window();
    bar_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write the period for one cycle while the block is idle
  task automatic write_period(input atr_pkg::period_t p);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_period(p);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    bar_if.valid       <= 1'b0;
    bar_if.high_price  <= '0;
    bar_if.low_price   <= '0;
    bar_if.prior_close <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset period
    send_random(50, 1'b0);
    drain_window();

    // period 1: every bar returns its own true range
    write_period(atr_pkg::period_t'(1));
    send_bar('0, '0, '0);
    send_bar('1, '0, '0);
    send_bar('1, '0, '1);
    send_bar('0, '1, '0);
    send_bar('1, '1, '0);
    send_bar('0, '0, '1);
    send_bar('1, '1, '1);
    send_bar(32'd100, 32'd200, 32'd150);
    send_bar(32'd500, 32'd100, 32'd300);
    send_bar(32'd500, 32'd100, 32'd2000);
    send_bar(32'd500, 32'd100, 32'd0);
    send_bar(32'd1000, 32'd3000, 32'd5000);
    send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_bar(32'h1234_5678, 32'h1234_5678, 32'h1234_5678);
    drain_window();

    // period zero acts as one
    write_period(atr_pkg::period_t'(0));
    send_random(30, 1'b0);
    drain_window();

    // period 2 with a long receiver hold so the block backs up
    write_period(atr_pkg::period_t'(2));
    long_holds_asked++;
    send_random(80, 1'b0);
    drain_window();

    // full window
    write_period(atr_pkg::period_t'(256));
    send_random(270, 1'b0);
    drain_window();

    // largest code clamps to the full window; all ranges maximal
    write_period(atr_pkg::period_t'(511));
    send_random(265, 1'b1);
    drain_window();

    // rewriting the same period restarts the window
    write_period(atr_pkg::period_t'(7));
    send_random(80, 1'b0);
    drain_window();
    write_period(atr_pkg::period_t'(7));
    send_random(40, 1'b0);
    drain_window();

    // last part at full rate, no gaps or stalls
    idle_enabled = 1'b0;
    write_period(atr_pkg::period_t'($urandom_range(3, 20)));
    send_random(100, 1'b0);
    drain_window();

    sb.check_leftovers();
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> average_true_range.f
+incdir+hw/rtl
hw/rtl/atr_pkg.sv
hw/rtl/atr_if.sv
hw/rtl/atr_tr.sv
hw/rtl/atr_ring.sv
hw/rtl/atr_div.sv
hw/rtl/average_true_range.sv
tb/average_true_range_tb.sv
